### rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg: shared constants and helpers for the segregated-fit extent allocator
// Holds the default sizes, the result status codes and the top-bit encoder.
// ----------------------------------------------------------------------------
package sfa_pkg;

    // Default sizes handed to the module parameters.
    localparam int ENTRIES_DEF   = 64;
    localparam int BIN_COUNT_DEF = 32;
    localparam int ADDR_BITS_DEF = 32;

    // Result status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NO_FIT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Position of the highest set bit; zero for an input of zero or one.
    function automatic logic [4:0] top_bit(input logic [31:0] x);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

### rtl/segregated_fit_extent_allocator_core.sv
// ----------------------------------------------------------------------------
// segregated_fit_extent_allocator_core: extent allocator with power-of-two bins
// Frees merge with adjacent extents; allocations take the newest extent of the
// lowest fitting bin and re-file the tail. The table is a chain of slot cells.
//
//   Channel | Signals                                   | Beat
//   --------+-------------------------------------------+-------------------
//   in      | in_valid, in_ready, action, base_addr,     | one request
//           | length                                    |
//   out     | out_valid, out_ready, granted_addr,        | one result per
//           | status, free_total                        | request
//
// A search beat walks the cell chain one slot per cycle. A free runs one
// scan; an allocate runs one scan, and a second one when a tail is re-filed;
// a zero-length request skips the scan, as does an allocate that finds no
// occupied bin at or above its size.
// One request is in work at a time; a new one is taken while the previous
// result waits in the output register. Reset clears all slots at once.
// ----------------------------------------------------------------------------
module segregated_fit_extent_allocator_core #(
    parameter int ENTRIES   = sfa_pkg::ENTRIES_DEF,
    parameter int BIN_COUNT = sfa_pkg::BIN_COUNT_DEF,
    parameter int ADDR_BITS = sfa_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] base_addr,
    input  logic [31:0] length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] granted_addr,
    output logic [1:0]  status,
    output logic [31:0] free_total
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int AW    = ADDR_BITS;

    typedef struct packed {
        logic             newest;
        logic [AW-1:0]    base;
        logic [AW:0]      lim;
        logic [BIN_W-1:0] bin;
        logic [31:0]      count;
    } qry_t;

    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic [AW-1:0]    base;
        logic [AW-1:0]    len;
        logic [BIN_W-1:0] bin;
        logic [31:0]      stamp;
        logic             kill;
        logic [IDX_W-1:0] kill_idx;
    } wcmd_t;

    typedef struct packed {
        logic             vld;
        logic             a_hit;
        logic [IDX_W-1:0] a_idx;
        logic [AW-1:0]    a_base;
        logic [AW-1:0]    a_len;
        logic [BIN_W-1:0] a_bin;
        logic [31:0]      a_age;
        logic             b_hit;
        logic [IDX_W-1:0] b_idx;
        logic [AW-1:0]    b_len;
        logic [BIN_W-1:0] b_bin;
        logic             e_hit;
        logic [IDX_W-1:0] e_idx;
    } tok_t;

    typedef struct packed {
        logic             dec_a;
        logic [BIN_W-1:0] a_bin;
        logic             dec_b;
        logic [BIN_W-1:0] b_bin;
        logic             inc;
        logic [BIN_W-1:0] inc_bin;
    } upd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APREP,
        S_ABIN,
        S_SCAN,
        S_ACHK,
        S_FPREV,
        S_FNEXT,
        S_FINISH
    } state_t;

    // Bin of a length, clamped to the top bin.
    function automatic logic [BIN_W-1:0] bin_of(input logic [AW-1:0] len);
        logic [4:0] tb;
        tb = sfa_pkg::top_bit(32'(len));
        if (32'(tb) >= 32'(BIN_COUNT - 1))
        begin
            return BIN_W'(BIN_COUNT - 1);
        end
        return BIN_W'(tb);
    endfunction

    state_t           st_reg,      st_next;
    logic             launch_reg,  launch_next;
    logic             newest_reg,  newest_next;
    logic [AW-1:0]    qbase_reg,   qbase_next;
    logic [AW-1:0]    qlen_reg,    qlen_next;
    logic [BIN_W-1:0] qbin_reg,    qbin_next;
    logic [AW-1:0]    reqlen_reg,  reqlen_next;
    logic [5:0]       minbit_reg,  minbit_next;
    tok_t             hold_reg,    hold_next;
    logic             usep_reg,    usep_next;
    logic [AW-1:0]    total_reg,   total_next;
    logic [AW-1:0]    resaddr_reg, resaddr_next;
    logic [1:0]       resst_reg,   resst_next;
    logic [31:0]      ic_reg,      ic_next;
    logic [31:0]      sum_reg,     sum_next;
    logic             ovld_reg,    ovld_next;
    logic [31:0]      oaddr_reg,   oaddr_next;
    logic [1:0]       ost_reg,     ost_next;
    logic [31:0]      otot_reg,    otot_next;

    qry_t                 query;
    wcmd_t                wcmd;
    upd_t                 upd;
    tok_t                 start_tok;
    tok_t                 chain [ENTRIES];
    logic [BIN_COUNT-1:0] occupied;

    // Broadcast search key; the upper end is formed from the held request.
    always_comb
    begin
        query.newest = newest_reg;
        query.base   = qbase_reg;
        query.lim    = {1'b0, qbase_reg} + {1'b0, qlen_reg};
        query.bin    = qbin_reg;
        query.count  = ic_reg;
    end

    always_comb
    begin
        start_tok     = '0;
        start_tok.vld = launch_reg;
    end

    // Chain of table slots.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        tok_t cin;
        if (g == 0)
        begin : g_head
            assign cin = start_tok;
        end
        else
        begin : g_link
            assign cin = chain[g-1];
        end
        sfa_cell #(
            .ENTRIES   (ENTRIES),
            .BIN_COUNT (BIN_COUNT),
            .ADDR_BITS (ADDR_BITS),
            .IDX       (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .query   (query),
            .wcmd    (wcmd),
            .tok_in  (cin),
            .tok_out (chain[g])
        );
    end

    sfa_bins #(
        .ENTRIES   (ENTRIES),
        .BIN_COUNT (BIN_COUNT)
    ) u_bins (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .occupied (occupied)
    );

    // Request sequencer.
    always_comb
    begin
        logic [AW-1:0] len_m;
        logic [AW-1:0] base_m;
        logic [4:0]    tb;
        logic          found;
        logic [BIN_W-1:0] sel;
        logic [AW:0]   psum;
        logic [AW:0]   nsum;
        logic          usen;
        logic [AW-1:0] tot;
        logic [AW-1:0] diff;

        st_next      = st_reg;
        launch_next  = 1'b0;
        newest_next  = newest_reg;
        qbase_next   = qbase_reg;
        qlen_next    = qlen_reg;
        qbin_next    = qbin_reg;
        reqlen_next  = reqlen_reg;
        minbit_next  = minbit_reg;
        hold_next    = hold_reg;
        usep_next    = usep_reg;
        total_next   = total_reg;
        resaddr_next = resaddr_reg;
        resst_next   = resst_reg;
        ic_next      = ic_reg;
        sum_next     = sum_reg;
        ovld_next    = ovld_reg && !out_ready;
        oaddr_next   = oaddr_reg;
        ost_next     = ost_reg;
        otot_next    = otot_reg;
        wcmd         = '0;
        upd          = '0;

        len_m  = length[AW-1:0];
        base_m = base_addr[AW-1:0];
        tb     = sfa_pkg::top_bit(32'(reqlen_reg));
        found  = 1'b0;
        sel    = '0;
        psum   = {1'b0, qlen_reg} + {1'b0, hold_reg.a_len};
        nsum   = {1'b0, total_reg} + {1'b0, hold_reg.b_len};
        usen   = hold_reg.b_hit && !nsum[AW];
        tot    = usen ? nsum[AW-1:0] : total_reg;
        diff   = hold_reg.a_len - reqlen_reg;

        unique case (st_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    reqlen_next  = len_m;
                    resaddr_next = '0;
                    resst_next   = sfa_pkg::ST_DONE;
                    if (len_m == '0)
                    begin
                        resst_next = action ? sfa_pkg::ST_NO_FIT : sfa_pkg::ST_DONE;
                        st_next    = S_FINISH;
                    end
                    else if (!action)
                    begin
                        qbase_next  = base_m;
                        qlen_next   = len_m;
                        newest_next = 1'b0;
                        launch_next = 1'b1;
                        st_next     = S_SCAN;
                    end
                    else
                    begin
                        st_next = S_APREP;
                    end
                end
            end
            S_APREP:
            begin
                // Round the size up to a power of two.
                minbit_next = {1'b0, tb} +
                    6'((reqlen_reg & (reqlen_reg - AW'(1))) != '0);
                st_next = S_ABIN;
            end
            S_ABIN:
            begin
                for (int b = 0; b < BIN_COUNT; b++)
                begin
                    if (!found && occupied[b] && 6'(b) >= minbit_reg)
                    begin
                        found = 1'b1;
                        sel   = BIN_W'(b);
                    end
                end
                if (32'(minbit_reg) >= 32'(BIN_COUNT) || !found)
                begin
                    resst_next = sfa_pkg::ST_NO_FIT;
                    st_next    = S_FINISH;
                end
                else
                begin
                    qbin_next   = sel;
                    newest_next = 1'b1;
                    launch_next = 1'b1;
                    st_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain[ENTRIES-1].vld)
                begin
                    hold_next = chain[ENTRIES-1];
                    st_next   = newest_reg ? S_ACHK : S_FPREV;
                end
            end
            S_ACHK:
            begin
                if (!hold_reg.a_hit || hold_reg.a_len < reqlen_reg)
                begin
                    resst_next = sfa_pkg::ST_NO_FIT;
                    st_next    = S_FINISH;
                end
                else
                begin
                    // Take the newest extent and re-file any tail.
                    resaddr_next  = hold_reg.a_base;
                    wcmd.kill     = 1'b1;
                    wcmd.kill_idx = hold_reg.a_idx;
                    upd.dec_a     = 1'b1;
                    upd.a_bin     = hold_reg.a_bin;
                    sum_next      = sum_reg - 32'(hold_reg.a_len);
                    if (diff != '0)
                    begin
                        qbase_next  = hold_reg.a_base + reqlen_reg;
                        qlen_next   = diff;
                        newest_next = 1'b0;
                        launch_next = 1'b1;
                        st_next     = S_SCAN;
                    end
                    else
                    begin
                        st_next = S_FINISH;
                    end
                end
            end
            S_FPREV:
            begin
                usep_next  = hold_reg.a_hit && !psum[AW];
                total_next = (hold_reg.a_hit && !psum[AW]) ? psum[AW-1:0] : qlen_reg;
                st_next    = S_FNEXT;
            end
            S_FNEXT:
            begin
                if (!usep_reg && !usen && !hold_reg.e_hit)
                begin
                    resst_next = sfa_pkg::ST_FULL;
                end
                else
                begin
                    // File the merged extent and retire absorbed neighbors.
                    wcmd.wr       = 1'b1;
                    wcmd.wr_idx   = usep_reg ? hold_reg.a_idx :
                                    (usen ? hold_reg.b_idx : hold_reg.e_idx);
                    wcmd.base     = usep_reg ? hold_reg.a_base : qbase_reg;
                    wcmd.len      = tot;
                    wcmd.bin      = bin_of(tot);
                    wcmd.stamp    = ic_reg;
                    wcmd.kill     = usep_reg && usen;
                    wcmd.kill_idx = hold_reg.b_idx;
                    upd.dec_a     = usep_reg;
                    upd.a_bin     = hold_reg.a_bin;
                    upd.dec_b     = usen;
                    upd.b_bin     = hold_reg.b_bin;
                    upd.inc       = 1'b1;
                    upd.inc_bin   = bin_of(tot);
                    ic_next       = ic_reg + 32'd1;
                    sum_next      = sum_reg + 32'(qlen_reg);
                end
                st_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next  = 1'b1;
                    oaddr_next = 32'(resaddr_reg);
                    ost_next   = resst_reg;
                    otot_next  = sum_reg;
                    st_next    = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            launch_reg <= 1'b0;
            ic_reg     <= '0;
            sum_reg    <= '0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            launch_reg <= launch_next;
            ic_reg     <= ic_next;
            sum_reg    <= sum_next;
            ovld_reg   <= ovld_next;
        end
    end

    // Request payload and result holding registers.
    always_ff @(posedge clk)
    begin
        newest_reg  <= newest_next;
        qbase_reg   <= qbase_next;
        qlen_reg    <= qlen_next;
        qbin_reg    <= qbin_next;
        reqlen_reg  <= reqlen_next;
        minbit_reg  <= minbit_next;
        hold_reg    <= hold_next;
        usep_reg    <= usep_next;
        total_reg   <= total_next;
        resaddr_reg <= resaddr_next;
        resst_reg   <= resst_next;
        oaddr_reg   <= oaddr_next;
        ost_reg     <= ost_next;
        otot_reg    <= otot_next;
    end

    assign in_ready     = st_reg == S_IDLE;
    assign out_valid    = ovld_reg;
    assign granted_addr = oaddr_reg;
    assign status       = ost_reg;
    assign free_total   = otot_reg;

`ifndef NO_ASSERTIONS
    // A search beat only leaves the chain while a scan is pending.
    a_beat_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[ENTRIES-1].vld |-> st_reg == S_SCAN)
        else $error("search beat left the chain outside a scan");

    // A launch is always followed by waiting in the scan state.
    a_launch_scan: assert property (@(posedge clk) disable iff (!rst_n)
        launch_reg |-> st_reg == S_SCAN)
        else $error("search launched outside a scan");

    // Filing and retiring never target the same slot.
    a_wr_kill: assert property (@(posedge clk) disable iff (!rst_n)
        (wcmd.wr && wcmd.kill) |-> wcmd.wr_idx != wcmd.kill_idx)
        else $error("slot filed and retired in the same cycle");

    // An accepted request leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> st_reg != S_IDLE)
        else $error("request accepted without leaving idle");
`endif

endmodule

### rtl/sfa_cell.sv
// ----------------------------------------------------------------------------
// sfa_cell: one slot of the extent table
// Holds one extent and folds its own match into the search beat that passes
// down the chain, registering the beat for the next cell.
// ----------------------------------------------------------------------------
module sfa_cell #(
    parameter int ENTRIES   = sfa_pkg::ENTRIES_DEF,
    parameter int BIN_COUNT = sfa_pkg::BIN_COUNT_DEF,
    parameter int ADDR_BITS = sfa_pkg::ADDR_BITS_DEF,
    parameter int IDX       = 0
) (clk, rst_n, query, wcmd, tok_in, tok_out);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int AW    = ADDR_BITS;

    typedef struct packed {
        logic             newest;
        logic [AW-1:0]    base;
        logic [AW:0]      lim;
        logic [BIN_W-1:0] bin;
        logic [31:0]      count;
    } qry_t;

    typedef struct packed {
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        logic [AW-1:0]    base;
        logic [AW-1:0]    len;
        logic [BIN_W-1:0] bin;
        logic [31:0]      stamp;
        logic             kill;
        logic [IDX_W-1:0] kill_idx;
    } wcmd_t;

    typedef struct packed {
        logic             vld;
        logic             a_hit;
        logic [IDX_W-1:0] a_idx;
        logic [AW-1:0]    a_base;
        logic [AW-1:0]    a_len;
        logic [BIN_W-1:0] a_bin;
        logic [31:0]      a_age;
        logic             b_hit;
        logic [IDX_W-1:0] b_idx;
        logic [AW-1:0]    b_len;
        logic [BIN_W-1:0] b_bin;
        logic             e_hit;
        logic [IDX_W-1:0] e_idx;
    } tok_t;

    input  logic  clk;
    input  logic  rst_n;
    input  qry_t  query;
    input  wcmd_t wcmd;
    input  tok_t  tok_in;
    output tok_t  tok_out;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic             valid_reg;
    logic [AW-1:0]    base_reg;
    logic [AW-1:0]    len_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [31:0]      stamp_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [31:0]      age;
    logic             prev_match;
    logic             next_match;

    // Match terms against this slot's extent.
    assign age        = query.count - stamp_reg;
    assign prev_match = ({1'b0, base_reg} + {1'b0, len_reg}) == {1'b0, query.base};
    assign next_match = {1'b0, base_reg} == query.lim;

    // Fold this slot into the passing search beat.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.vld)
        begin
            if (query.newest)
            begin
                if (valid_reg && bin_reg == query.bin &&
                    (!tok_in.a_hit || age < tok_in.a_age))
                begin
                    tok_next.a_hit  = 1'b1;
                    tok_next.a_idx  = MY_IDX;
                    tok_next.a_base = base_reg;
                    tok_next.a_len  = len_reg;
                    tok_next.a_bin  = bin_reg;
                    tok_next.a_age  = age;
                end
            end
            else
            begin
                if (valid_reg && !tok_in.a_hit && prev_match)
                begin
                    tok_next.a_hit  = 1'b1;
                    tok_next.a_idx  = MY_IDX;
                    tok_next.a_base = base_reg;
                    tok_next.a_len  = len_reg;
                    tok_next.a_bin  = bin_reg;
                end
                if (valid_reg && !tok_in.b_hit && next_match)
                begin
                    tok_next.b_hit = 1'b1;
                    tok_next.b_idx = MY_IDX;
                    tok_next.b_len = len_reg;
                    tok_next.b_bin = bin_reg;
                end
                if (!valid_reg && !tok_in.e_hit)
                begin
                    tok_next.e_hit = 1'b1;
                    tok_next.e_idx = MY_IDX;
                end
            end
        end
    end

    // Slot storage and the registered beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wcmd.wr && wcmd.wr_idx == MY_IDX)
            begin
                valid_reg <= 1'b1;
            end
            else if (wcmd.kill && wcmd.kill_idx == MY_IDX)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Extent payload, written only when filed.
    always_ff @(posedge clk)
    begin
        if (wcmd.wr && wcmd.wr_idx == MY_IDX)
        begin
            base_reg  <= wcmd.base;
            len_reg   <= wcmd.len;
            bin_reg   <= wcmd.bin;
            stamp_reg <= wcmd.stamp;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/sfa_bins.sv
// ----------------------------------------------------------------------------
// sfa_bins: bin occupancy tracker
// Keeps a count of filed extents per bin and reports which bins are in use.
// ----------------------------------------------------------------------------
module sfa_bins #(
    parameter int ENTRIES   = sfa_pkg::ENTRIES_DEF,
    parameter int BIN_COUNT = sfa_pkg::BIN_COUNT_DEF
) (clk, rst_n, upd, occupied);

    localparam int BIN_W = $clog2(BIN_COUNT);
    localparam int CW    = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic             dec_a;
        logic [BIN_W-1:0] a_bin;
        logic             dec_b;
        logic [BIN_W-1:0] b_bin;
        logic             inc;
        logic [BIN_W-1:0] inc_bin;
    } upd_t;

    input  logic                 clk;
    input  logic                 rst_n;
    input  upd_t                 upd;
    output logic [BIN_COUNT-1:0] occupied;

    logic [CW-1:0] cnt_reg  [BIN_COUNT];
    logic [CW-1:0] cnt_next [BIN_COUNT];

    // Per-bin count update; each bin is independent.
    always_comb
    begin
        for (int b = 0; b < BIN_COUNT; b++)
        begin
            cnt_next[b] = cnt_reg[b]
                - CW'(upd.dec_a && upd.a_bin == BIN_W'(b))
                - CW'(upd.dec_b && upd.b_bin == BIN_W'(b))
                + CW'(upd.inc && upd.inc_bin == BIN_W'(b));
            occupied[b] = cnt_reg[b] != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < BIN_COUNT; b++)
            begin
                cnt_reg[b] <= '0;
            end
        end
        else
        begin
            for (int b = 0; b < BIN_COUNT; b++)
            begin
                cnt_reg[b] <= cnt_next[b];
            end
        end
    end

endmodule

### test/sfa_checker.sv
// ----------------------------------------------------------------------------
// sfa_checker: result checker for the segregated-fit extent allocator
// Watches both channels, keeps its own copy of the extent table, predicts
// the result of each accepted request and compares it with the output beat.
// ----------------------------------------------------------------------------
module sfa_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        action,
    input  logic [31:0] base_addr,
    input  logic [31:0] length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] granted_addr,
    input  logic [1:0]  status,
    input  logic [31:0] free_total,
    output int          fail_count,
    output int          pending
);

    localparam int SLOTS = sfa_pkg::ENTRIES_DEF;
    localparam int BINS  = sfa_pkg::BIN_COUNT_DEF;

    typedef struct packed {
        logic [31:0] grant;
        logic [1:0]  stat;
        logic [31:0] total;
    } alloc_result_t;

    // Shadow copy of the allocator state.
    logic [31:0] ext_base  [SLOTS];
    logic [31:0] ext_len   [SLOTS];
    logic [31:0] ext_stamp [SLOTS];
    logic        ext_used  [SLOTS];
    logic [31:0] file_count;
    logic [31:0] bins_busy;
    logic [31:0] sum_free;

    alloc_result_t result_queue[$];

    function automatic int msb_pos(logic [31:0] x);
        int pos;
        pos = 0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                pos = i;
            end
        end
        return pos;
    endfunction

    function automatic int bin_for(logic [31:0] len);
        int b;
        b = msb_pos(len);
        return (b >= BINS) ? BINS - 1 : b;
    endfunction

    function automatic void file_slot(int slot, logic [31:0] b, logic [31:0] len);
        ext_used[slot]  = 1'b1;
        ext_base[slot]  = b;
        ext_len[slot]   = len;
        ext_stamp[slot] = file_count;
        file_count      = file_count + 1;
        sum_free        = sum_free + len;
        bins_busy[bin_for(len)] = 1'b1;
    endfunction

    function automatic void clear_slot(int slot);
        int  b;
        logic still;
        b = bin_for(ext_len[slot]);
        still = 1'b0;
        ext_used[slot] = 1'b0;
        sum_free = sum_free - ext_len[slot];
        for (int i = 0; i < SLOTS; i++)
        begin
            if (ext_used[i] && bin_for(ext_len[i]) == b)
            begin
                still = 1'b1;
            end
        end
        if (!still)
        begin
            bins_busy[b] = 1'b0;
        end
    endfunction

    // Merge with neighbors and file; returns the status of the insertion.
    function automatic logic [1:0] merge_and_file(logic [31:0] b, logic [31:0] len);
        int         prev_slot;
        int         next_slot;
        int         slot;
        logic [32:0] end_addr;
        logic [32:0] total;
        logic [31:0] new_base;
        prev_slot = -1;
        next_slot = -1;
        slot = -1;
        end_addr = {1'b0, b} + len;
        total = {1'b0, len};
        new_base = b;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (ext_used[i])
            begin
                if (prev_slot < 0 && {1'b0, ext_base[i]} + ext_len[i] == {1'b0, b})
                begin
                    prev_slot = i;
                end
                if (next_slot < 0 && {1'b0, ext_base[i]} == end_addr)
                begin
                    next_slot = i;
                end
            end
        end
        if (prev_slot >= 0 && total + ext_len[prev_slot] > 33'hFFFF_FFFF)
        begin
            prev_slot = -1;
        end
        if (prev_slot >= 0)
        begin
            total = total + ext_len[prev_slot];
            new_base = ext_base[prev_slot];
        end
        if (next_slot >= 0 && total + ext_len[next_slot] > 33'hFFFF_FFFF)
        begin
            next_slot = -1;
        end
        if (next_slot >= 0)
        begin
            total = total + ext_len[next_slot];
        end
        if (prev_slot >= 0)
        begin
            slot = prev_slot;
        end
        else if (next_slot >= 0)
        begin
            slot = next_slot;
        end
        else
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (!ext_used[i])
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                return sfa_pkg::ST_FULL;
            end
        end
        if (prev_slot >= 0)
        begin
            clear_slot(prev_slot);
        end
        if (next_slot >= 0)
        begin
            clear_slot(next_slot);
        end
        file_slot(slot, new_base, total[31:0]);
        return sfa_pkg::ST_DONE;
    endfunction

    function automatic alloc_result_t predict_request(logic act, logic [31:0] b,
                                                      logic [31:0] len);
        alloc_result_t r;
        int          need;
        int          pick_bin;
        int          best;
        logic [31:0] best_age;
        logic [31:0] age;
        logic [31:0] rest;
        r.grant = '0;
        r.stat  = sfa_pkg::ST_DONE;
        best = -1;
        best_age = '0;
        pick_bin = -1;
        if (act == 1'b0)
        begin
            if (len != 0)
            begin
                r.stat = merge_and_file(b, len);
            end
        end
        else if (len == 0)
        begin
            r.stat = sfa_pkg::ST_NO_FIT;
        end
        else
        begin
            need = msb_pos(len);
            if (len != (32'd1 << need))
            begin
                need++;
            end
            if (need < BINS)
            begin
                for (int i = BINS - 1; i >= need; i--)
                begin
                    if (bins_busy[i])
                    begin
                        pick_bin = i;
                    end
                end
            end
            if (pick_bin < 0)
            begin
                r.stat = sfa_pkg::ST_NO_FIT;
            end
            else
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (ext_used[i] && bin_for(ext_len[i]) == pick_bin)
                    begin
                        age = file_count - ext_stamp[i];
                        if (best < 0 || age < best_age)
                        begin
                            best = i;
                            best_age = age;
                        end
                    end
                end
                if (best < 0 || ext_len[best] < len)
                begin
                    r.stat = sfa_pkg::ST_NO_FIT;
                end
                else
                begin
                    rest = ext_len[best] - len;
                    r.grant = ext_base[best];
                    clear_slot(best);
                    if (rest != 0)
                    begin
                        void'(merge_and_file(r.grant + len, rest));
                    end
                end
            end
        end
        r.total = sum_free;
        return r;
    endfunction

    assign pending = result_queue.size();

    // Predict on request beats and compare on result beats.
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                ext_used[i] = 1'b0;
            end
            file_count = '0;
            bins_busy  = '0;
            sum_free   = '0;
            fail_count <= 0;
            result_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("unexpected result beat: grant %h status %0d total %h",
                                 granted_addr, status, free_total);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (want.grant !== granted_addr || want.stat !== status ||
                        want.total !== free_total)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("result mismatch: expected grant %h status %0d total %h",
                                     want.grant, want.stat, want.total);
                            $display("                 actual   grant %h status %0d total %h",
                                     granted_addr, status, free_total);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                result_queue.push_back(predict_request(action, base_addr, length));
            end
        end
    end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the segregated-fit extent allocator
// Drives directed and random free/allocate requests under varying idle and
// stall patterns; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [31:0] base_addr;
    logic [31:0] length;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] granted_addr;
    logic [1:0]  status;
    logic [31:0] free_total;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_off;
    int          quiet_cycles;
    logic [31:0] next_base;

    segregated_fit_extent_allocator_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .base_addr    (base_addr),
        .length       (length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_addr (granted_addr),
        .status       (status),
        .free_total   (free_total)
    );

    sfa_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .base_addr    (base_addr),
        .length       (length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_addr (granted_addr),
        .status       (status),
        .free_total   (free_total),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Receiver: random stalls, plus an optional long hold-off.
    always @(posedge clk)
    begin
        out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Send one request beat, with random idle cycles ahead of it. Valid is
    // left high after the accepting edge; the next call either replaces the
    // beat or drops valid for an idle cycle.
    task automatic send_request(logic act, logic [31:0] b, logic [31:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        base_addr <= b;
        length    <= len;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    // Short random length: mostly small, sometimes huge.
    function automatic logic [31:0] pick_length();
        case ($urandom_range(9))
            0: return $urandom();
            1: return 32'd1 << $urandom_range(31);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    // One random request, biased toward well-formed free/allocate traffic.
    task automatic random_request();
        logic [31:0] len;
        int          kind;
        kind = $urandom_range(99);
        len = pick_length();
        if (kind < 45)
        begin
            // Fresh extents, often adjacent to the previous one so they merge.
            if ($urandom_range(3) != 0)
            begin
                send_request(1'b0, next_base, len);
            end
            else
            begin
                send_request(1'b0, $urandom(), len);
            end
            next_base = next_base + len + (($urandom_range(2) == 0) ? 32'd16 : 32'd0);
        end
        else if (kind < 90)
        begin
            send_request(1'b1, $urandom(), len);
        end
        else
        begin
            send_request(1'($urandom_range(1)), $urandom(),
                         ($urandom_range(3) == 0) ? 32'd0 : len);
        end
    endtask

    initial
    begin
        int ph;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = 1'b0;
        base_addr      = '0;
        length         = '0;
        out_ready      = 1'b0;
        hold_off       = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        next_base      = 32'h1000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero lengths, exact fit, merges, overflow cases, big sizes.
        send_request(1'b1, 32'h0, 32'd0);
        send_request(1'b0, 32'h0, 32'd0);
        send_request(1'b1, 32'h0, 32'd8);
        send_request(1'b0, 32'h100, 32'd16);
        send_request(1'b0, 32'h110, 32'd16);
        send_request(1'b0, 32'hF0, 32'd16);
        send_request(1'b1, 32'h0, 32'd5);
        send_request(1'b1, 32'h0, 32'd64);
        send_request(1'b1, 32'h0, 32'd43);
        send_request(1'b0, 32'h0, 32'hFFFF_FFFF);
        send_request(1'b0, 32'hFFFF_FFFF, 32'd1);
        send_request(1'b1, 32'h0, 32'h8000_0001);
        send_request(1'b1, 32'h0, 32'hFFFF_FFFF);
        send_request(1'b1, 32'h0, 32'h8000_0000);
        send_request(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_request(1'b0, 32'h0, 32'h8000_0000);
        send_request(1'b1, 32'h0, 32'd1);
        // Fill the table with isolated extents so a further free is dropped.
        for (int i = 0; i < 70; i++)
        begin
            send_request(1'b0, 32'h2000_0000 + i * 32'h40, 32'd8);
        end
        for (int i = 0; i < 70; i++)
        begin
            send_request(1'b1, 32'h0, 32'd8);
        end

        // Random phases with different idle patterns.
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 32 : 87) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 32 : 87) : 0;
            if (ph == 0)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 200; k++)
            begin
                random_request();
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);

        // Drain, then allow for the block's latency.
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
